/* src/bed_pkg.sv */
// shared types and constants for the banded edit distance row engine
// field widths, opcodes, register indexes, controller/datapath command and status
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bed_pkg;

  localparam int OP_W     = 1;
  localparam int POS_W    = 6;
  localparam int SYM_W    = 8;
  localparam int SCORE_W  = 6;
  localparam int QLEN_W   = 6;
  localparam int DIST_W   = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 6;

  localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
  localparam logic [OP_W-1:0] OP_ROW  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_QLEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DIST = 1'b1;

  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  localparam logic [SCORE_W-1:0] INF_SCORE = 6'd63;

  typedef struct packed {
    logic take;
    logic decode;
    logic issue;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic run;
    logic last_issue;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

/* src/bed_ctrl.sv */
// controller state machine: request intake, decode, band sweep, result hand-off
// depends on bed_pkg for the command and status structs
`timescale 1ns / 1ps
`default_nettype none

module bed_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bed_pkg::dp_status_t  status,
  output bed_pkg::dp_cmd_t     cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DEC   = 5'b00010,
    S_RUN   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.decode = 1'b1;
        if (status.run) begin
          state_nxt = S_RUN;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_RUN: begin
        cmd.issue = 1'b1;
        if (status.last_issue) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last cell of the band is scored this cycle
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  a_take_then_decode: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> cmd.decode)
    else $error("decode did not follow an accepted request");

  a_sweep_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.decode && status.run |=> cmd.issue)
    else $error("band sweep did not start after decode");

  a_sweep_stops: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue && status.last_issue |=> !cmd.issue)
    else $error("reads issued past the end of the band");
`endif

endmodule

`default_nettype wire

/* src/bed_datapath.sv */
// datapath: config registers, request registers, query symbol and score memories,
// band cell update and result register; driven by bed_ctrl through bed_pkg structs
`timescale 1ns / 1ps
`default_nettype none

module bed_datapath #(
  parameter int MAX_QUERY = 32,
  parameter int DIST_CAP  = 7,
  parameter int MAX_ROWS  = 40
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bed_pkg::dp_cmd_t                   cmd,
  output bed_pkg::dp_status_t                status,
  input  logic                               cfg_we,
  input  logic [bed_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bed_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [bed_pkg::OP_W-1:0]           in_opcode,
  input  logic [bed_pkg::POS_W-1:0]          in_position,
  input  logic [bed_pkg::SYM_W-1:0]          in_symbol,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_status,
  output logic [bed_pkg::SCORE_W-1:0]        out_row_score,
  output logic [bed_pkg::SCORE_W-1:0]        out_best_future,
  output logic                               out_within_limit,
  output logic                               out_worth_extending
);

  localparam int QA_W  = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
  localparam int SA_W  = $clog2(MAX_ROWS * MAX_QUERY);
  localparam int CMP_W = $clog2(MAX_ROWS + MAX_QUERY + DIST_CAP + 64);
  localparam int SW    = bed_pkg::SCORE_W;
  localparam int PW    = bed_pkg::POS_W;
  localparam int XW    = bed_pkg::QLEN_W;
  localparam int DW    = bed_pkg::DIST_W;

  function automatic logic [bed_pkg::SCORE_W-1:0] inc_sat(
    input logic [bed_pkg::SCORE_W-1:0] v,
    input logic                        inc
  );
    logic [bed_pkg::SCORE_W-1:0] r;
    r = (v == bed_pkg::INF_SCORE) ? bed_pkg::INF_SCORE : v + {{(bed_pkg::SCORE_W-1){1'b0}}, inc};
    return r;
  endfunction

  // memories
  logic [bed_pkg::SYM_W-1:0] qsym_mem  [MAX_QUERY];
  logic [SW-1:0]             score_mem [MAX_ROWS * MAX_QUERY];

  // configuration
  logic [bed_pkg::QLEN_W-1:0] qlen_r;
  logic [DW-1:0]              dist_r;

  // request
  logic [bed_pkg::OP_W-1:0]   op_r;
  logic [PW-1:0]              pos_r;
  logic [bed_pkg::SYM_W-1:0]  sym_r;

  // per-row setup
  logic [XW-1:0]   lo_r, hi_r, q_r;
  logic [DW-1:0]   d_r;
  logic [XW:0]     ulim_r;
  logic            ym1_zero_r;
  logic            reject_r;
  logic [SA_W-1:0] rd_base_r, wr_base_r;

  // sweep
  logic [XW-1:0]             rd_x_r;
  logic                      p_valid_r;
  logic [XW-1:0]             p_x_r;
  logic [bed_pkg::SYM_W-1:0] qsym_rd_r;
  logic [SW-1:0]             score_rd_r;
  logic [SW-1:0]             diag_r, left_r, best_r, rs_r;

  // result register
  logic          out_valid_r;
  logic          out_status_r;
  logic [SW-1:0] out_row_score_r, out_best_r;
  logic          out_wl_r, out_we_r;

  // decode
  logic [XW-1:0]   q_eff;
  logic [DW-1:0]   d_eff;
  logic [XW:0]     y7, d7, sum7;
  logic [XW-1:0]   lo_c, hi_c;
  logic            reject_c;
  logic            load_ok;
  logic [SA_W-1:0] rd_base_c;

  // cell update
  logic [SW-1:0] up_c, diag_v, left_v, up_v, s_c, s2_c;
  logic          cost_c, prime_c, at_q_c;

  always_comb begin
    if (qlen_r == '0) begin
      q_eff = XW'(1);
    end else if (CMP_W'(qlen_r) > CMP_W'(MAX_QUERY)) begin
      q_eff = XW'(MAX_QUERY);
    end else begin
      q_eff = qlen_r;
    end
    d_eff = (CMP_W'(dist_r) > CMP_W'(DIST_CAP)) ? DW'(DIST_CAP) : dist_r;

    y7   = {1'b0, pos_r};
    d7   = (XW+1)'(d_eff);
    sum7 = y7 + d7;
    lo_c = (y7 > d7 + (XW+1)'(1)) ? pos_r - PW'(d_eff) : XW'(1);
    hi_c = (sum7 < (XW+1)'(q_eff)) ? sum7[XW-1:0] : q_eff;

    if (op_r == bed_pkg::OP_LOAD) begin
      reject_c = (pos_r == '0) || (CMP_W'(pos_r) > CMP_W'(MAX_QUERY));
    end else begin
      reject_c = (pos_r == '0) || (CMP_W'(pos_r) >= CMP_W'(MAX_ROWS));
    end
    load_ok   = (op_r == bed_pkg::OP_LOAD) && !reject_c;
    rd_base_c = SA_W'(pos_r - PW'(1)) * SA_W'(MAX_QUERY);
  end

  assign status.run        = (op_r == bed_pkg::OP_ROW) && !reject_c && (lo_c <= hi_c);
  assign status.last_issue = (rd_x_r == hi_r);
  assign status.out_free   = !out_valid_r || !out_stall;

  // cell of the previous row in this column; row 0 is the column number itself
  always_comb begin
    if (ym1_zero_r) begin
      up_c = SW'(p_x_r);
    end else if ((XW+1)'(p_x_r) <= ulim_r) begin
      up_c = score_rd_r;
    end else begin
      up_c = bed_pkg::INF_SCORE;
    end
    cost_c  = (qsym_rd_r != sym_r);
    prime_c = (p_x_r < lo_r);
    at_q_c  = (p_x_r == q_r);
    diag_v  = inc_sat(diag_r, cost_c);
    left_v  = inc_sat(left_r, 1'b1);
    up_v    = inc_sat(up_c, 1'b1);
    s_c     = (diag_v < left_v) ? diag_v : left_v;
    s_c     = (up_v < s_c) ? up_v : s_c;
    // the last column needs one more edit to stay reachable from deeper rows
    s2_c    = at_q_c ? inc_sat(s_c, 1'b1) : s_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlen_r <= bed_pkg::QLEN_W'(1);
      dist_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bed_pkg::REG_QLEN: qlen_r <= cfg_data;
        bed_pkg::REG_DIST: dist_r <= cfg_data[DW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r  <= in_opcode;
      pos_r <= in_position;
      sym_r <= in_symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && cmd.decode) begin
      qsym_mem[QA_W'(pos_r - PW'(1))] <= sym_r;
    end
    if (cmd.issue) begin
      qsym_rd_r <= qsym_mem[QA_W'(rd_x_r - XW'(1))];
    end
  end

  always_ff @(posedge clk) begin
    if (p_valid_r && !prime_c) begin
      score_mem[wr_base_r + SA_W'(p_x_r - XW'(1))] <= s_c;
    end
    if (cmd.issue) begin
      score_rd_r <= score_mem[rd_base_r + SA_W'(rd_x_r - XW'(1))];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      lo_r       <= lo_c;
      hi_r       <= hi_c;
      q_r        <= q_eff;
      d_r        <= d_eff;
      ulim_r     <= y7 - (XW+1)'(1) + d7;
      ym1_zero_r <= (pos_r == PW'(1));
      reject_r   <= reject_c;
      rd_base_r  <= rd_base_c;
      wr_base_r  <= rd_base_c + SA_W'(MAX_QUERY);
      // band past column 1 starts with a read of the diagonal neighbor only
      rd_x_r     <= (lo_c > XW'(1)) ? lo_c - XW'(1) : lo_c;
      diag_r     <= pos_r - PW'(1);
      left_r     <= (lo_c == XW'(1)) ? pos_r : bed_pkg::INF_SCORE;
      best_r     <= bed_pkg::INF_SCORE;
      rs_r       <= bed_pkg::INF_SCORE;
    end else begin
      if (cmd.issue) begin
        rd_x_r <= rd_x_r + XW'(1);
        p_x_r  <= rd_x_r;
      end
      if (p_valid_r) begin
        diag_r <= up_c;
        if (!prime_c) begin
          left_r <= s_c;
          best_r <= (s2_c < best_r) ? s2_c : best_r;
          if (at_q_c) begin
            rs_r <= s_c;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r    <= reject_r ? bed_pkg::STATUS_RANGE : bed_pkg::STATUS_DONE;
      out_row_score_r <= rs_r;
      out_best_r      <= best_r;
      out_wl_r        <= (rs_r <= SW'(d_r));
      out_we_r        <= (best_r <= SW'(d_r));
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_row_score       = out_row_score_r;
  assign out_best_future     = out_best_r;
  assign out_within_limit    = out_wl_r;
  assign out_worth_extending = out_we_r;

`ifndef SYNTH
  a_cell_in_band: assert property (@(posedge clk) disable iff (!rst_n)
    p_valid_r |-> (p_x_r <= hi_r) && ((XW+1)'(p_x_r) + (XW+1)'(1) >= (XW+1)'(lo_r)))
    else $error("scored column outside the band");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while held");

  a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && (rs_r != bed_pkg::INF_SCORE) |->
      ((SW+1)'(best_r) <= (SW+1)'(rs_r) + (SW+1)'(1)))
    else $error("future bound above last column score plus one");
`endif

endmodule

`default_nettype wire

/* src/banded_edit_distance_row_core.sv */
// a row request is decoded, then sweeps its band cells, then waits for a free result register;
// a band that starts past column 1 begins with a read of the diagonal neighbor; loads, rejects
// and rows with an empty band skip the sweep and go from decode straight to the result
// requests are taken one at a time: in_stall holds off the next until the result is written;
// the sweep reads one band cell per cycle through the single read port of the score memory
// reset: synchronous active-low rst_n clears control, query length 1 and distance limit 0;
// symbol and score memories are not cleared and hold nothing until written
`timescale 1ns / 1ps
`default_nettype none

module banded_edit_distance_row_core #(
  parameter int MAX_QUERY = 32,
  parameter int DIST_CAP  = 7,
  parameter int MAX_ROWS  = 40
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bed_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bed_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bed_pkg::OP_W-1:0]       in_opcode,
  input  logic [bed_pkg::POS_W-1:0]      in_position,
  input  logic [bed_pkg::SYM_W-1:0]      in_symbol,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_status,
  output logic [bed_pkg::SCORE_W-1:0]    out_row_score,
  output logic [bed_pkg::SCORE_W-1:0]    out_best_future,
  output logic                           out_within_limit,
  output logic                           out_worth_extending
);

  bed_pkg::dp_cmd_t    cmd;
  bed_pkg::dp_status_t status;

  bed_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  bed_datapath #(
    .MAX_QUERY (MAX_QUERY),
    .DIST_CAP  (DIST_CAP),
    .MAX_ROWS  (MAX_ROWS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_opcode           (in_opcode),
    .in_position         (in_position),
    .in_symbol           (in_symbol),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_row_score       (out_row_score),
    .out_best_future     (out_best_future),
    .out_within_limit    (out_within_limit),
    .out_worth_extending (out_worth_extending)
  );

endmodule

`default_nettype wire
